FILE: rtl/searchable_fifo_queue_defines.svh
// assertion macros for the searchable fifo queue checker
// no dependencies; included by the checker file only
`ifndef SEARCHABLE_FIFO_QUEUE_DEFINES_SVH
`define SEARCHABLE_FIFO_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on the checker clock, off during reset
`define SFQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("searchable fifo queue check failed");

// next-cycle implication
`define SFQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("searchable fifo queue check failed");

`endif

FILE: rtl/sfq_pkg.sv
// shared types and constants for the searchable fifo queue
// no dependencies; used by the store, the top level and the checker
`default_nettype none

package sfq_pkg;

    // entry count, a power of two so the ring pointers wrap by themselves
    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_LOCATE = 3'd2;
    localparam logic [2:0] CMD_STATUS = 3'd3;
    localparam logic [2:0] CMD_LIST   = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] operand_value;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_value;
        logic [4:0]         position;
        logic [4:0]         fill_count;
        logic               last;
    } t_result_word;

    typedef struct packed {
        logic               en;
        logic [AW-1:0]      addr;
        logic signed [31:0] data;
    } t_wr_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_SCAN,
        S_LIST
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/sfq_store.sv
// entry memory: one write port, one read port with registered read data
// depends on sfq_pkg
`default_nettype none

module sfq_store (
    input  wire logic                       i_clk,
    input  wire sfq_pkg::t_wr_req           i_wr,
    input  wire logic [sfq_pkg::AW-1:0]     i_rd_addr,
    output logic signed [31:0]              o_rd_data
);

    logic signed [31:0] mem [sfq_pkg::DEPTH];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/searchable_fifo_queue.sv
// searchable fifo queue top level: command decode, ring pointers and result register
// depends on sfq_pkg and sfq_store
//
// A command word is taken when start is high and busy is low. Insert and status
// never raise busy: their result shows in the next cycle and a new command may
// follow at once. Remove passes through a remove state that takes the head entry.
// Locate compares the entries one at a time, head first, and stops at the first
// match or after the last entry. List streams one entry per cycle, head first,
// with last set on the final word. Empty or full cases answer without raising
// busy. The scans use the single read port of the entry memory, which returns
// one entry per cycle with registered read data. Results are held on o_result
// for exactly one cycle, marked by o_strobe, and cannot be stalled.
// Unused command codes are dropped without a result.
`default_nettype none

module searchable_fifo_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire sfq_pkg::t_cmd_word    i_cmd,
    output logic                       o_strobe,
    output sfq_pkg::t_result_word      o_result
);

    sfq_pkg::t_state       r_state, n_state;
    logic [sfq_pkg::AW-1:0] r_head, n_head;
    logic [sfq_pkg::CW-1:0] r_count, n_count;
    logic [sfq_pkg::AW-1:0] r_idx, n_idx;
    logic signed [31:0]     r_key, n_key;
    logic                   r_strobe, n_strobe;
    sfq_pkg::t_result_word  r_res, n_res;

    sfq_pkg::t_wr_req       wr;
    logic [sfq_pkg::AW-1:0] rd_addr;
    logic signed [31:0]     rd_data;
    logic [sfq_pkg::CW-1:0] idx_inc;

    sfq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign idx_inc = {1'b0, r_idx} + sfq_pkg::CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sfq_pkg::S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_res <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_key    = r_key;
        n_strobe = 1'b0;
        n_res    = r_res;
        wr.en    = 1'b0;
        wr.addr  = r_head + r_count[sfq_pkg::AW-1:0];
        wr.data  = i_cmd.operand_value;
        rd_addr  = r_head + idx_inc[sfq_pkg::AW-1:0];

        case (r_state)
            sfq_pkg::S_IDLE: begin
                rd_addr = r_head;
                n_res.status     = sfq_pkg::STAT_OK;
                n_res.data_value = '0;
                n_res.position   = '0;
                n_res.fill_count = 5'(r_count);
                n_res.last       = 1'b1;
                if (start) begin
                    case (i_cmd.command)
                        sfq_pkg::CMD_INSERT: begin
                            n_strobe = 1'b1;
                            if (r_count == sfq_pkg::CW'(sfq_pkg::DEPTH)) begin
                                n_res.status = sfq_pkg::STAT_FULL;
                            end else begin
                                wr.en            = 1'b1;
                                n_count          = r_count + sfq_pkg::CW'(1);
                                n_res.fill_count = 5'(r_count + sfq_pkg::CW'(1));
                            end
                        end
                        sfq_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_strobe     = 1'b1;
                                n_res.status = sfq_pkg::STAT_EMPTY;
                            end else begin
                                n_state = sfq_pkg::S_REMOVE;
                            end
                        end
                        sfq_pkg::CMD_LOCATE: begin
                            if (r_count == '0) begin
                                n_strobe     = 1'b1;
                                n_res.status = sfq_pkg::STAT_EMPTY;
                            end else begin
                                n_key   = i_cmd.operand_value;
                                n_idx   = '0;
                                n_state = sfq_pkg::S_SCAN;
                            end
                        end
                        sfq_pkg::CMD_STATUS: begin
                            n_strobe = 1'b1;
                        end
                        sfq_pkg::CMD_LIST: begin
                            if (r_count == '0) begin
                                n_strobe     = 1'b1;
                                n_res.status = sfq_pkg::STAT_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = sfq_pkg::S_LIST;
                            end
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end
            sfq_pkg::S_REMOVE: begin
                n_strobe         = 1'b1;
                n_res.status     = sfq_pkg::STAT_OK;
                n_res.data_value = rd_data;
                n_res.position   = '0;
                n_res.fill_count = 5'(r_count - sfq_pkg::CW'(1));
                n_res.last       = 1'b1;
                n_count          = r_count - sfq_pkg::CW'(1);
                n_head           = r_head + sfq_pkg::AW'(1);
                n_state          = sfq_pkg::S_IDLE;
            end
            sfq_pkg::S_SCAN: begin
                n_res.data_value = '0;
                n_res.fill_count = 5'(r_count);
                n_res.last       = 1'b1;
                if (rd_data == r_key) begin
                    n_strobe       = 1'b1;
                    n_res.status   = sfq_pkg::STAT_OK;
                    n_res.position = 5'(idx_inc);
                    n_state        = sfq_pkg::S_IDLE;
                end else if (idx_inc == r_count) begin
                    n_strobe       = 1'b1;
                    n_res.status   = sfq_pkg::STAT_NOTFOUND;
                    n_res.position = '0;
                    n_state        = sfq_pkg::S_IDLE;
                end else begin
                    n_idx = idx_inc[sfq_pkg::AW-1:0];
                end
            end
            sfq_pkg::S_LIST: begin
                n_strobe         = 1'b1;
                n_res.status     = sfq_pkg::STAT_OK;
                n_res.data_value = rd_data;
                n_res.position   = 5'(idx_inc);
                n_res.fill_count = 5'(r_count);
                n_res.last       = (idx_inc == r_count);
                if (idx_inc == r_count) begin
                    n_state = sfq_pkg::S_IDLE;
                end else begin
                    n_idx = idx_inc[sfq_pkg::AW-1:0];
                end
            end
            default: begin
                n_state = sfq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != sfq_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

FILE: rtl/sfq_checker.sv
// port-level checks for the searchable fifo queue, bound to the top level
// depends on sfq_pkg and searchable_fifo_queue_defines.svh
`default_nettype none

`include "searchable_fifo_queue_defines.svh"

module sfq_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire sfq_pkg::t_cmd_word    i_cmd,
    input wire logic                  o_strobe,
    input wire sfq_pkg::t_result_word o_result
);

    // a list stream has no gaps
    `SFQ_ASSERT_NEXT(a_stream_gapless, o_strobe && !o_result.last, o_strobe)

    // insert answers in the next cycle with a single word
    `SFQ_ASSERT_NEXT(a_insert_answer,
        start && !busy && i_cmd.command == sfq_pkg::CMD_INSERT,
        o_strobe && o_result.last)

    // a rejected insert only happens at capacity
    `SFQ_ASSERT_NOW(a_full_at_depth,
        o_strobe && o_result.status == sfq_pkg::STAT_FULL,
        o_result.fill_count == 5'(sfq_pkg::DEPTH))

    // an empty answer reports no entries and no position
    `SFQ_ASSERT_NOW(a_empty_consistent,
        o_strobe && o_result.status == sfq_pkg::STAT_EMPTY,
        o_result.fill_count == '0 && o_result.position == '0 && o_result.last)

endmodule

bind searchable_fifo_queue sfq_checker u_sfq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
